[rtl/tcb_pkg.sv]
// ----------------------------------------------------------------------------
// tcb_pkg
// Shared widths, register indexes and types for the barycentric triangle block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcb_pkg;

    localparam int COORD_BITS       = 16;
    localparam int ATTR_BITS        = 16;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WEIGHT_BITS      = WEIGHT_FRAC_BITS + 4;
    localparam int DIFF_BITS        = COORD_BITS + 1;
    localparam int EDGE_BITS        = 2 * DIFF_BITS + 1;
    localparam int MAG_BITS         = EDGE_BITS - 1;
    localparam int QBITS            = WEIGHT_FRAC_BITS + 4;
    localparam int DIV_STEPS        = QBITS;
    localparam int ADDR_BITS        = 3;
    localparam int SUM_BITS         = WEIGHT_BITS + ATTR_BITS + 2;

    localparam logic [ADDR_BITS-1:0] REG_AX = 3'd0;
    localparam logic [ADDR_BITS-1:0] REG_AY = 3'd1;
    localparam logic [ADDR_BITS-1:0] REG_BX = 3'd2;
    localparam logic [ADDR_BITS-1:0] REG_BY = 3'd3;
    localparam logic [ADDR_BITS-1:0] REG_CX = 3'd4;
    localparam logic [ADDR_BITS-1:0] REG_CY = 3'd5;

    typedef struct packed {
        logic                         covered;
        logic                         degen;
        logic signed [ATTR_BITS-1:0]  attr_a;
        logic signed [ATTR_BITS-1:0]  attr_b;
        logic signed [ATTR_BITS-1:0]  attr_c;
    } t_side;

endpackage

`default_nettype wire

[rtl/triangle_coverage_barycentric.sv]
// ----------------------------------------------------------------------------
// triangle_coverage_barycentric
// Edge-function coverage test with barycentric weights and attribute blend.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle unless stalled; divider pipeline sets the depth.
// A stall freezes the whole pipeline; the output register holds the result.
// Reset clears valid bits and the vertex registers to zero.
`default_nettype none

module triangle_coverage_barycentric
    import tcb_pkg::*;
(
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_stall,
    input  wire  signed [COORD_BITS-1:0]  i_point_x,
    input  wire  signed [COORD_BITS-1:0]  i_point_y,
    input  wire  signed [ATTR_BITS-1:0]   i_attr_a,
    input  wire  signed [ATTR_BITS-1:0]   i_attr_b,
    input  wire  signed [ATTR_BITS-1:0]   i_attr_c,
    input  wire                           i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire  [ADDR_BITS-1:0]          i_cfg_index,
    input  wire  [COORD_BITS-1:0]         i_cfg_data,
    output logic                          o_valid,
    input  wire                           i_stall,
    output logic                          o_inside_res,
    output logic                          o_degenerate,
    output logic signed [WEIGHT_BITS-1:0] o_weight_a,
    output logic signed [WEIGHT_BITS-1:0] o_weight_b,
    output logic signed [WEIGHT_BITS-1:0] o_weight_c,
    output logic signed [ATTR_BITS-1:0]   o_attr_out
);

    localparam int DEPTH = DIV_STEPS + 6;

    logic signed [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic [DEPTH-1:0] r_vld;
    logic             w_en;

    assign o_cfg_ready = 1'b1;
    assign w_en        = !(o_valid && i_stall);
    assign o_stall     = !w_en;
    assign o_valid     = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0; r_ay <= '0; r_bx <= '0; r_by <= '0; r_cx <= '0; r_cy <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_AX:  r_ax <= i_cfg_data;
                REG_AY:  r_ay <= i_cfg_data;
                REG_BX:  r_bx <= i_cfg_data;
                REG_BY:  r_by <= i_cfg_data;
                REG_CX:  r_cx <= i_cfg_data;
                REG_CY:  r_cy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    // stage 1: differences
    logic signed [DIFF_BITS-1:0] r_pax, r_pay, r_pbx, r_pby, r_pcx, r_pcy;
    logic signed [DIFF_BITS-1:0] r_abx, r_aby, r_bcx, r_bcy, r_cax, r_cay, r_acx, r_acy;
    t_side r_s1;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pax <= DIFF_BITS'(i_point_x) - DIFF_BITS'(r_ax);
            r_pay <= DIFF_BITS'(i_point_y) - DIFF_BITS'(r_ay);
            r_pbx <= DIFF_BITS'(i_point_x) - DIFF_BITS'(r_bx);
            r_pby <= DIFF_BITS'(i_point_y) - DIFF_BITS'(r_by);
            r_pcx <= DIFF_BITS'(i_point_x) - DIFF_BITS'(r_cx);
            r_pcy <= DIFF_BITS'(i_point_y) - DIFF_BITS'(r_cy);
            r_abx <= DIFF_BITS'(r_bx) - DIFF_BITS'(r_ax);
            r_aby <= DIFF_BITS'(r_by) - DIFF_BITS'(r_ay);
            r_bcx <= DIFF_BITS'(r_cx) - DIFF_BITS'(r_bx);
            r_bcy <= DIFF_BITS'(r_cy) - DIFF_BITS'(r_by);
            r_cax <= DIFF_BITS'(r_ax) - DIFF_BITS'(r_cx);
            r_cay <= DIFF_BITS'(r_ay) - DIFF_BITS'(r_cy);
            r_acx <= DIFF_BITS'(r_cx) - DIFF_BITS'(r_ax);
            r_acy <= DIFF_BITS'(r_cy) - DIFF_BITS'(r_ay);
            r_s1  <= '{1'b0, 1'b0, i_attr_a, i_attr_b, i_attr_c};
        end
    end

    // stage 2: products
    logic signed [EDGE_BITS-2:0] r_m [10];
    t_side r_s2;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m[0] <= r_pax * r_aby;  r_m[1] <= r_pay * r_abx;
            r_m[2] <= r_pbx * r_bcy;  r_m[3] <= r_pby * r_bcx;
            r_m[4] <= r_pcx * r_cay;  r_m[5] <= r_pcy * r_cax;
            r_m[6] <= r_pax * r_acy;  r_m[7] <= r_pay * r_acx;
            r_m[8] <= r_acx * r_aby;  r_m[9] <= r_acy * r_abx;
            r_s2   <= r_s1;
        end
    end

    // stage 3: edge values, signs, magnitudes
    logic signed [EDGE_BITS-1:0] w_e0, w_e1, w_e2, w_bn, w_gd;
    always_comb begin
        w_e0 = EDGE_BITS'(r_m[0]) - EDGE_BITS'(r_m[1]);
        w_e1 = EDGE_BITS'(r_m[2]) - EDGE_BITS'(r_m[3]);
        w_e2 = EDGE_BITS'(r_m[4]) - EDGE_BITS'(r_m[5]);
        w_bn = EDGE_BITS'(r_m[6]) - EDGE_BITS'(r_m[7]);
        w_gd = EDGE_BITS'(r_m[8]) - EDGE_BITS'(r_m[9]);
    end

    logic [MAG_BITS-1:0] r_bnm, r_gnm, r_dm;
    logic                r_bneg, r_gneg;
    t_side               r_s3;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bnm  <= MAG_BITS'(w_bn < 0 ? -w_bn : w_bn);
            r_gnm  <= MAG_BITS'(w_e0 < 0 ? -w_e0 : w_e0);
            r_dm   <= MAG_BITS'(w_gd < 0 ? -w_gd : w_gd);
            // b_den = -g_den
            r_bneg <= (w_bn < 0) == (w_gd < 0) && w_bn != 0;
            r_gneg <= (w_e0 < 0) != (w_gd < 0) && w_e0 != 0;
            r_s3   <= '{(w_e0 >= 0) == (w_e1 >= 0) && (w_e1 >= 0) == (w_e2 >= 0),
                        w_gd == 0, r_s2.attr_a, r_s2.attr_b, r_s2.attr_c};
        end
    end

    logic signed [WEIGHT_BITS-1:0] w_wb, w_wc;
    tcb_div u_div_b (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_num(r_bnm),
                     .i_den(r_dm), .i_neg(r_bneg), .o_q(w_wb));
    tcb_div u_div_c (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_num(r_gnm),
                     .i_den(r_dm), .i_neg(r_gneg), .o_q(w_wc));

    t_side r_sd [DIV_STEPS+1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= r_s3;
            for (int k = 0; k < DIV_STEPS; k++) r_sd[k+1] <= r_sd[k];
        end
    end

    // alpha and products
    logic signed [WEIGHT_BITS+1:0] w_wa_raw;
    logic signed [WEIGHT_BITS-1:0] w_wa;
    localparam logic signed [WEIGHT_BITS+1:0] WMAX = (WEIGHT_BITS+2)'(1) <<< (WEIGHT_BITS-1);
    always_comb begin
        w_wa_raw = ((WEIGHT_BITS+2)'(1) <<< WEIGHT_FRAC_BITS) - (WEIGHT_BITS+2)'(w_wb)
                   - (WEIGHT_BITS+2)'(w_wc);
        if (w_wa_raw >= WMAX)       w_wa = WEIGHT_BITS'(WMAX - 1);
        else if (w_wa_raw < -WMAX)  w_wa = WEIGHT_BITS'(-WMAX);
        else                        w_wa = WEIGHT_BITS'(w_wa_raw);
    end

    logic signed [WEIGHT_BITS+ATTR_BITS-1:0] r_pa, r_pb, r_pc;
    logic signed [WEIGHT_BITS-1:0]           r_wa, r_wb, r_wc;
    logic                                    r_in5, r_dg5;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa  <= w_wa * r_sd[DIV_STEPS].attr_a;
            r_pb  <= w_wb * r_sd[DIV_STEPS].attr_b;
            r_pc  <= w_wc * r_sd[DIV_STEPS].attr_c;
            r_wa  <= w_wa; r_wb <= w_wb; r_wc <= w_wc;
            r_in5 <= r_sd[DIV_STEPS].covered;
            r_dg5 <= r_sd[DIV_STEPS].degen;
        end
    end

    logic signed [SUM_BITS-1:0] w_sum;
    logic [SUM_BITS-1:0]        w_mag;
    logic [SUM_BITS-1:0]        w_rnd;
    logic signed [ATTR_BITS-1:0] w_attr;
    always_comb begin
        w_sum = SUM_BITS'(r_pa) + SUM_BITS'(r_pb) + SUM_BITS'(r_pc);
        w_mag = w_sum < 0 ? SUM_BITS'(-w_sum) : SUM_BITS'(w_sum);
        w_rnd = (w_mag + (SUM_BITS'(1) << (WEIGHT_FRAC_BITS - 1))) >> WEIGHT_FRAC_BITS;
        if (w_sum < 0) begin
            w_attr = (w_rnd >= (SUM_BITS'(1) << (ATTR_BITS - 1)))
                     ? {1'b1, {(ATTR_BITS-1){1'b0}}} : -ATTR_BITS'(w_rnd);
        end else begin
            w_attr = (w_rnd >= (SUM_BITS'(1) << (ATTR_BITS - 1)))
                     ? {1'b0, {(ATTR_BITS-1){1'b1}}} : ATTR_BITS'(w_rnd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_inside_res <= r_in5;
            o_degenerate <= r_dg5;
            o_weight_a   <= r_dg5 ? '0 : r_wa;
            o_weight_b   <= r_dg5 ? '0 : r_wb;
            o_weight_c   <= r_dg5 ? '0 : r_wc;
            o_attr_out   <= r_dg5 ? '0 : w_attr;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_attr_out))
        else $error("result changed under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_weight_a == '0 && o_attr_out == '0)
        else $error("degenerate result not zeroed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("stall without output back-pressure");

endmodule

`default_nettype wire

[rtl/tcb_div.sv]
// ----------------------------------------------------------------------------
// tcb_div
// Pipelined restoring divider: one quotient bit per stage, rounds half away
// from zero and saturates to signed Q3.F.
// ----------------------------------------------------------------------------
`default_nettype none

module tcb_div
    import tcb_pkg::*;
(
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_en,
    input  wire  [MAG_BITS-1:0]           i_num,
    input  wire  [MAG_BITS-1:0]           i_den,
    input  wire                           i_neg,
    output logic signed [WEIGHT_BITS-1:0] o_q
);

    localparam int RW        = MAG_BITS + 1;
    localparam int CW        = MAG_BITS + 3;
    localparam int INT_STEPS = 3;

    logic [RW-1:0]       r_rem  [DIV_STEPS+1];
    logic [MAG_BITS-1:0] r_den  [DIV_STEPS+1];
    logic [QBITS-1:0]    r_q    [DIV_STEPS+1];
    logic                r_neg  [DIV_STEPS+1];
    logic                r_bigs [DIV_STEPS+1];

    // Flag quotients of 8 or more up front; the rest fits three integer bits.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {1'b0, i_num};
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_neg[0]  <= i_neg;
            r_bigs[0] <= {3'b000, i_num} >= {i_den, 3'b000};
        end
    end

    genvar g;
    generate
        for (g = 0; g < DIV_STEPS; g++) begin : g_step
            logic [CW-1:0] w_rem;
            logic [CW-1:0] w_den;
            logic          w_ge;
            if (g < INT_STEPS) begin : g_int
                assign w_rem = CW'(r_rem[g]);
                assign w_den = CW'(r_den[g]) << (INT_STEPS - 1 - g);
            end else begin : g_frac
                assign w_rem = CW'(r_rem[g]) << 1;
                assign w_den = CW'(r_den[g]);
            end
            assign w_ge = w_rem >= w_den;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g+1]  <= w_ge ? RW'(w_rem - w_den) : RW'(w_rem);
                    r_q[g+1]    <= {r_q[g][QBITS-2:0], w_ge};
                    r_den[g+1]  <= r_den[g];
                    r_neg[g+1]  <= r_neg[g];
                    r_bigs[g+1] <= r_bigs[g];
                end
            end
        end
    endgenerate

    logic [QBITS:0]   w_rnd;
    logic [QBITS-1:0] w_m;
    logic [QBITS-1:0] w_lim;
    always_comb begin
        w_lim = QBITS'(1) << (WEIGHT_FRAC_BITS + 3);
        w_rnd = ({1'b0, r_q[DIV_STEPS]} + (QBITS+1)'(1)) >> 1;
        w_m   = w_rnd[QBITS-1:0];
        if (r_bigs[DIV_STEPS] || w_m >= w_lim) begin
            o_q = r_neg[DIV_STEPS] ? -WEIGHT_BITS'(w_lim) : WEIGHT_BITS'(w_lim - QBITS'(1));
        end else begin
            o_q = r_neg[DIV_STEPS] ? -WEIGHT_BITS'(w_m) : WEIGHT_BITS'(w_m);
        end
    end

    logic unused_rst;
    assign unused_rst = i_rst_n;

endmodule

`default_nettype wire
